// File: hdl/tst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_pkg: shared types and constants of the triangle tessellator
// Beat payloads, the job record between normal unit and emitter, and the
// normal unit's sequencer states.
// ----------------------------------------------------------------------------
package tst_pkg;

  // subdivisions per side and derived grid sizes
  localparam int TST_D  = 8;
  localparam int TST_NV = (TST_D + 1) * (TST_D + 2) / 2;
  localparam int TST_RW = $clog2(TST_D + 1);
  localparam int TST_VW = $clog2(TST_NV);
  // r*a + c*b accumulator, a and b are 33 bit edges
  localparam int TST_AW = 40;

  typedef struct packed {
    logic signed [31:0] apex_x;
    logic signed [31:0] apex_y;
    logic signed [31:0] apex_z;
    logic signed [31:0] left_x;
    logic signed [31:0] left_y;
    logic signed [31:0] left_z;
    logic signed [31:0] right_x;
    logic signed [31:0] right_y;
    logic signed [31:0] right_z;
    logic [15:0]        base_index;
  } tst_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [1:0]         tri_mask;
    logic [15:0]        idx_self;
    logic [15:0]        idx_left;
    logic [15:0]        idx_up_left;
    logic [15:0]        idx_up;
    logic               last;
  } tst_out_t;

  // one triangle ready for emission
  typedef struct packed {
    logic [2:0][31:0] apex;
    logic [2:0][32:0] ea;    // left - apex
    logic [2:0][32:0] eb;    // right - left
    logic [2:0][15:0] nrm;
    logic [15:0]      base;
  } tst_job_t;

  typedef enum logic [3:0] {
    NS_IDLE, NS_SHRA, NS_MUL, NS_DIFF, NS_NSHR, NS_SQ, NS_SQRT, NS_DIV, NS_DONE
  } tst_nstate_t;

endpackage

// File: hdl/tst_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_norm: edge vectors and flat unit normal of one triangle
// Sequenced unit: scale edges, cross product on two multipliers, scale the
// normal, sum of squares, radix-4 square root, radix-4 rounded division.
// ----------------------------------------------------------------------------
module tst_norm (
  input  logic              clk,
  input  logic              rst_n,
  input  tst_pkg::tst_in_t  tri_i,
  input  logic              tri_valid,
  output logic              tri_take,
  output tst_pkg::tst_job_t job_o,
  output logic              job_valid,
  input  logic              job_take
);
  import tst_pkg::*;

  tst_nstate_t      st_r, st_nxt;
  logic [3:0]       cnt_r;
  tst_job_t         job_r;
  logic [2:0][30:0] sa_r, sb_r;
  logic signed [61:0] prod_r [6];
  logic [2:0][61:0] nm_r;
  logic [2:0]       nneg_r;
  logic [63:0]      sum_r, x_r, rt_r, bit_r;
  logic [2:0][31:0] rem_r;
  logic [2:0][15:0] nlo_r, q_r;

  // scale an edge vector below 2^30 by one shared truncating shift
  function automatic logic [2:0][30:0] shr30(input logic [2:0][32:0] v);
    logic [2:0][33:0] m;
    logic [33:0]      mx;
    logic [2:0]       s;
    logic [33:0]      q;
    logic [2:0][30:0] res;
    mx = '0;
    for (int k = 0; k < 3; k++) begin
      m[k] = v[k][32] ? (34'd0 - {v[k][32], v[k]}) : {1'b0, v[k]};
      if (m[k] > mx) mx = m[k];
    end
    if (mx[33])      s = 3'd4;
    else if (mx[32]) s = 3'd3;
    else if (mx[31]) s = 3'd2;
    else if (mx[30]) s = 3'd1;
    else             s = 3'd0;
    for (int k = 0; k < 3; k++) begin
      q = m[k] >> s;
      res[k] = v[k][32] ? (31'd0 - q[30:0]) : q[30:0];
    end
    return res;
  endfunction

  // multiplier operand selection, two products per cycle
  logic signed [30:0] ma0, mb0, ma1, mb1;
  logic signed [61:0] pm0, pm1;
  always_comb begin
    case (cnt_r)
      4'd0: begin
        ma0 = sa_r[1]; mb0 = sb_r[2]; ma1 = sa_r[2]; mb1 = sb_r[1];
      end
      4'd1: begin
        ma0 = sa_r[2]; mb0 = sb_r[0]; ma1 = sa_r[0]; mb1 = sb_r[2];
      end
      default: begin
        ma0 = sa_r[0]; mb0 = sb_r[1]; ma1 = sa_r[1]; mb1 = sb_r[0];
      end
    endcase
    pm0 = ma0 * mb0;
    pm1 = ma1 * mb1;
  end

  // normal scaling: largest magnitude and shift choice
  logic [61:0] nmx;
  logic [1:0]  nsh;   // 0 done, 1 by one, 2 by four, 3 by eight
  always_comb begin
    nmx = nm_r[0];
    if (nm_r[1] > nmx) nmx = nm_r[1];
    if (nm_r[2] > nmx) nmx = nm_r[2];
    if (|nmx[61:38])      nsh = 2'd3;
    else if (|nmx[37:34]) nsh = 2'd2;
    else if (|nmx[33:31]) nsh = 2'd1;
    else                  nsh = 2'd0;
  end

  // sum of squares, one term per cycle
  logic [30:0] sq_op;
  logic [61:0] sq_val;
  logic [63:0] sum_nxt;
  always_comb begin
    case (cnt_r)
      4'd0:    sq_op = nm_r[0][30:0];
      4'd1:    sq_op = nm_r[1][30:0];
      default: sq_op = nm_r[2][30:0];
    endcase
    sq_val  = sq_op * sq_op;
    sum_nxt = sum_r + 64'(sq_val);
  end

  // two square root steps per cycle
  logic [63:0] x_nxt, rt_nxt, bit_nxt;
  always_comb begin
    x_nxt = x_r; rt_nxt = rt_r; bit_nxt = bit_r;
    for (int i = 0; i < 2; i++) begin
      if (x_nxt >= rt_nxt + bit_nxt) begin
        x_nxt  = x_nxt - (rt_nxt + bit_nxt);
        rt_nxt = (rt_nxt >> 1) + bit_nxt;
      end else begin
        rt_nxt = rt_nxt >> 1;
      end
      bit_nxt = bit_nxt >> 2;
    end
  end

  // division setup: N = |n|*16384 + len/2, remainder starts at N >> 16
  logic [31:0]      len;
  logic [2:0][45:0] numer;
  always_comb begin
    len = rt_nxt[31:0];
    for (int k = 0; k < 3; k++)
      numer[k] = {nm_r[k][30:0], 14'd0} + 46'(len[31:1]);
  end

  // two quotient bits per cycle for each component
  logic [2:0][31:0] rem_nxt;
  logic [2:0][15:0] nlo_nxt, q_nxt;
  logic [32:0]      rt;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rem_nxt[k] = rem_r[k];
      nlo_nxt[k] = nlo_r[k];
      q_nxt[k]   = q_r[k];
      for (int i = 0; i < 2; i++) begin
        rt = {rem_nxt[k], nlo_nxt[k][15]};
        nlo_nxt[k] = {nlo_nxt[k][14:0], 1'b0};
        if (rt >= {1'b0, rt_r[31:0]}) begin
          rt = rt - {1'b0, rt_r[31:0]};
          q_nxt[k] = {q_nxt[k][14:0], 1'b1};
        end else begin
          q_nxt[k] = {q_nxt[k][14:0], 1'b0};
        end
        rem_nxt[k] = rt[31:0];
      end
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      NS_IDLE: if (tri_valid) st_nxt = NS_SHRA;
      NS_SHRA: st_nxt = NS_MUL;
      NS_MUL:  if (cnt_r == 4'd2) st_nxt = NS_DIFF;
      NS_DIFF: st_nxt = NS_NSHR;
      NS_NSHR: if (nsh == 2'd0) st_nxt = NS_SQ;
      NS_SQ: begin
        if (cnt_r == 4'd2) st_nxt = (sum_nxt == 64'd0) ? NS_DONE : NS_SQRT;
      end
      NS_SQRT: if (cnt_r == 4'd15) st_nxt = NS_DIV;
      NS_DIV:  if (cnt_r == 4'd7) st_nxt = NS_DONE;
      NS_DONE: if (job_take) st_nxt = NS_IDLE;
      default: st_nxt = NS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    tri_take  = (st_r == NS_IDLE) && tri_valid;
    job_valid = (st_r == NS_DONE);
    job_o     = job_r;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= NS_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= (st_nxt != st_r) ? 4'd0 : cnt_r + 4'd1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      NS_IDLE: begin
        if (tri_valid) begin
          job_r.apex[0] <= tri_i.apex_x;
          job_r.apex[1] <= tri_i.apex_y;
          job_r.apex[2] <= tri_i.apex_z;
          job_r.ea[0] <= {tri_i.left_x[31], tri_i.left_x} - {tri_i.apex_x[31], tri_i.apex_x};
          job_r.ea[1] <= {tri_i.left_y[31], tri_i.left_y} - {tri_i.apex_y[31], tri_i.apex_y};
          job_r.ea[2] <= {tri_i.left_z[31], tri_i.left_z} - {tri_i.apex_z[31], tri_i.apex_z};
          job_r.eb[0] <= {tri_i.right_x[31], tri_i.right_x} - {tri_i.left_x[31], tri_i.left_x};
          job_r.eb[1] <= {tri_i.right_y[31], tri_i.right_y} - {tri_i.left_y[31], tri_i.left_y};
          job_r.eb[2] <= {tri_i.right_z[31], tri_i.right_z} - {tri_i.left_z[31], tri_i.left_z};
          job_r.base  <= tri_i.base_index;
        end
      end
      NS_SHRA: begin
        sa_r      <= shr30(job_r.ea);
        sb_r      <= shr30(job_r.eb);
        job_r.nrm <= '0;
        sum_r     <= '0;
      end
      NS_MUL: begin
        for (int k = 0; k < 4; k++) prod_r[k] <= prod_r[k + 2];
        prod_r[4] <= pm0;
        prod_r[5] <= pm1;
      end
      NS_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          logic signed [62:0] d;
          d = {prod_r[2*k][61], prod_r[2*k]} - {prod_r[2*k+1][61], prod_r[2*k+1]};
          nneg_r[k] <= d[62];
          nm_r[k]   <= d[62] ? 62'(63'd0 - d) : d[61:0];
        end
      end
      NS_NSHR: begin
        for (int k = 0; k < 3; k++) begin
          case (nsh)
            2'd3:    nm_r[k] <= nm_r[k] >> 8;
            2'd2:    nm_r[k] <= nm_r[k] >> 4;
            2'd1:    nm_r[k] <= nm_r[k] >> 1;
            default: nm_r[k] <= nm_r[k];
          endcase
        end
      end
      NS_SQ: begin
        sum_r <= sum_nxt;
        if (cnt_r == 4'd2) begin
          x_r   <= sum_nxt;
          rt_r  <= '0;
          bit_r <= 64'd1 << 62;
        end
      end
      NS_SQRT: begin
        x_r   <= x_nxt;
        rt_r  <= rt_nxt;
        bit_r <= bit_nxt;
        if (cnt_r == 4'd15) begin
          for (int k = 0; k < 3; k++) begin
            rem_r[k] <= {2'b00, numer[k][45:16]};
            nlo_r[k] <= numer[k][15:0];
            q_r[k]   <= '0;
          end
        end
      end
      NS_DIV: begin
        rem_r <= rem_nxt;
        nlo_r <= nlo_nxt;
        q_r   <= q_nxt;
        if (cnt_r == 4'd7) begin
          for (int k = 0; k < 3; k++)
            job_r.nrm[k] <= nneg_r[k] ? (16'd0 - q_nxt[k]) : q_nxt[k];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hdl/triangle_subdivision_tessellator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_subdivision_tessellator_top: uniform triangle tessellator
// Splits each side of a triangle into TST_D parts and emits one beat per
// grid vertex with position, flat unit normal and triangle indices.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload   | beats
//  in      | in_valid / in_stall | tst_in_t  | one per triangle
//  out     | out_valid/out_stall | tst_out_t | (D+1)(D+2)/2 per triangle, 45 at D=8
//
//  One output beat per cycle while unstalled, paced by the vertex emitter. The
//  normal unit works on the next triangle while the current one is emitted.
//  Emission runs through the vertex counters, two register stages and the
//  output register.
//  Reset is synchronous active low and clears all valid and state bits.
//  out_stall freezes the whole emit pipeline; nothing is dropped or repeated.
module triangle_subdivision_tessellator_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tst_pkg::tst_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tst_pkg::tst_out_t out_data
);
  import tst_pkg::*;

  // input skid register
  tst_in_t hold_r;
  logic    hold_v_r;
  logic    tri_take;

  assign in_stall = hold_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_v_r <= 1'b1;
    end else if (tri_take) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) hold_r <= in_data;
  end

  // normal unit
  tst_job_t job;
  logic     job_valid, job_take;

  tst_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .tri_i     (hold_r),
    .tri_valid (hold_v_r),
    .tri_take  (tri_take),
    .job_o     (job),
    .job_valid (job_valid),
    .job_take  (job_take)
  );

  // emitter sequencer
  tst_job_t                job_r;
  logic                    em_busy_r;
  logic [TST_RW-1:0]       r_r, c_r;
  logic [TST_VW-1:0]       v_r;
  logic signed [TST_AW-1:0] acc_r [3];
  logic signed [TST_AW-1:0] row_r [3];
  logic                    adv, issue, last_now;
  tst_out_t                out_r;
  logic                    out_v_r;

  assign adv      = !out_v_r || !out_stall;
  assign issue    = em_busy_r && adv;
  assign last_now = (v_r == TST_VW'(TST_NV - 1));
  assign job_take = job_valid && (!em_busy_r || (issue && last_now));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_busy_r <= 1'b0;
    end else if (job_take) begin
      em_busy_r <= 1'b1;
    end else if (issue && last_now) begin
      em_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      job_r <= job;
      r_r   <= '0;
      c_r   <= '0;
      v_r   <= '0;
      for (int k = 0; k < 3; k++) begin
        acc_r[k] <= '0;
        row_r[k] <= '0;
      end
    end else if (issue) begin
      v_r <= v_r + 1'b1;
      if (c_r == r_r) begin
        r_r <= r_r + 1'b1;
        c_r <= '0;
        for (int k = 0; k < 3; k++) begin
          row_r[k] <= row_r[k] + TST_AW'($signed(job_r.ea[k]));
          acc_r[k] <= row_r[k] + TST_AW'($signed(job_r.ea[k]));
        end
      end else begin
        c_r <= c_r + 1'b1;
        for (int k = 0; k < 3; k++)
          acc_r[k] <= acc_r[k] + TST_AW'($signed(job_r.eb[k]));
      end
    end
  end

  // stage 1: indices and mask
  logic [1:0]  mask;
  logic [15:0] vv, rr;
  assign vv      = 16'(v_r);
  assign rr      = 16'(r_r);
  assign mask[0] = (c_r != '0);
  assign mask[1] = (c_r != '0) && (c_r != r_r);

  logic                     s1_v_r;
  logic signed [TST_AW-1:0] s1_acc_r [3];
  tst_out_t                 s1_r;
  logic [2:0][31:0]         s1_apex_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_acc_r[0]        <= acc_r[0];
      s1_acc_r[1]        <= acc_r[1];
      s1_acc_r[2]        <= acc_r[2];
      s1_apex_r          <= job_r.apex;
      s1_r.pos_x         <= '0;
      s1_r.pos_y         <= '0;
      s1_r.pos_z         <= '0;
      s1_r.norm_x        <= job_r.nrm[0];
      s1_r.norm_y        <= job_r.nrm[1];
      s1_r.norm_z        <= job_r.nrm[2];
      s1_r.tri_mask      <= mask;
      s1_r.idx_self      <= vv + job_r.base;
      s1_r.idx_left      <= mask[0] ? (vv - 16'd1 + job_r.base) : 16'd0;
      s1_r.idx_up_left   <= (|mask) ? (vv - rr - 16'd1 + job_r.base) : 16'd0;
      s1_r.idx_up        <= mask[1] ? (vv - rr + job_r.base) : 16'd0;
      s1_r.last          <= last_now;
    end
  end

  // stage 2: divide by D, round half away from zero
  logic                     s2_v_r;
  logic [2:0][31:0]         s2_q_r;
  logic [2:0][31:0]         s2_apex_r;
  tst_out_t                 s2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic [TST_AW-1:0] m, qm;
        m  = s1_acc_r[k][TST_AW-1] ? (TST_AW'(0) - s1_acc_r[k]) : s1_acc_r[k];
        qm = (m + TST_AW'(TST_D / 2)) / TST_D;
        s2_q_r[k] <= s1_acc_r[k][TST_AW-1] ? (32'd0 - qm[31:0]) : qm[31:0];
      end
      s2_apex_r <= s1_apex_r;
      s2_r      <= s1_r;
    end
  end

  // stage 3: add apex into the output register
  tst_out_t out_nxt;
  always_comb begin
    out_nxt       = s2_r;
    out_nxt.pos_x = s2_apex_r[0] + s2_q_r[0];
    out_nxt.pos_y = s2_apex_r[1] + s2_q_r[1];
    out_nxt.pos_z = s2_apex_r[2] + s2_q_r[2];
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= out_nxt;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// File: hdl/tst_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_chk: port checker for the triangle tessellator
// Watches the result channel and the index fields it carries.
// ----------------------------------------------------------------------------
module tst_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input tst_pkg::tst_out_t out_data
);
  import tst_pkg::*;

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed under stall");

  // final vertex closes the last row: outer triangle only
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> out_data.tri_mask == 2'b01 && out_data.idx_up == 16'd0)
    else $error("bad mask on final vertex");

  // inner triangle only with outer triangle
  a_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.tri_mask[1] |-> out_data.tri_mask[0])
    else $error("inner triangle without outer");

  // no triangles means no neighbor indices
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.tri_mask == 2'b00 |->
      out_data.idx_left == 16'd0 && out_data.idx_up_left == 16'd0)
    else $error("neighbor index without triangle");

  // consecutive accepted vertices number up by one within a triangle
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last ##1 out_valid |->
      out_data.idx_self == $past(out_data.idx_self) + 16'd1)
    else $error("vertex numbering skipped");

endmodule

bind triangle_subdivision_tessellator_top tst_chk u_chk (.*);
